// ===== rtl/dual_debounce_event_queue_defines.svh =====
// assertion macros for the dual debounce event queue
// expects clk_i and rst_ni in the scope of every use
`ifndef DUAL_DEBOUNCE_EVENT_QUEUE_DEFINES_SVH
`define DUAL_DEBOUNCE_EVENT_QUEUE_DEFINES_SVH

// property checked at every clock edge outside reset
`define DDEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define DDEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ddeq_pkg.sv =====
// shared types and constants for the dual debounce event queue
// no dependencies
package ddeq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WINDOW_W = 16;

  localparam logic [WINDOW_W-1:0] BUTTON_WINDOW_RST = 16'd40;
  localparam logic [WINDOW_W-1:0] CASE_WINDOW_RST   = 16'd60;

  // register index as decoded from the word address
  localparam logic REG_BUTTON_WINDOW = 1'b0;
  localparam logic REG_CASE_WINDOW   = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE        = 2'd0,
    EV_BUTTON      = 2'd1,
    EV_CASE_CLOSED = 2'd2,
    EV_CASE_OPENED = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e        kind;
    logic [TIME_W-1:0]  stamp;
    logic               closed;
  } event_t;

  // per-channel debounce status
  typedef struct packed {
    logic fire;     // stable level changes on this poll
    logic level_q;  // stable level before this poll
    logic level_d;  // stable level after this poll
  } deb_status_t;

endpackage

// ===== rtl/ddeq_debounce.sv =====
// one debounce channel: last raw level, change time and stable level
// depends on ddeq_pkg
module ddeq_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [ddeq_pkg::TIME_W-1:0]   now_i,
  input  logic                          raw_i,
  input  logic [ddeq_pkg::WINDOW_W-1:0] window_i,
  output ddeq_pkg::deb_status_t         status_o
);

  logic                        last_raw_q;
  logic                        stable_q, stable_d;
  logic [ddeq_pkg::TIME_W-1:0] change_time_q, change_time_d;
  logic [ddeq_pkg::TIME_W-1:0] elapsed;
  logic                        fire;

  assign change_time_d = (raw_i != last_raw_q) ? now_i : change_time_q;
  // wrapping difference
  assign elapsed  = now_i - change_time_d;
  assign fire     = (stable_q != raw_i) &&
                    (elapsed >= {{(ddeq_pkg::TIME_W-ddeq_pkg::WINDOW_W){1'b0}}, window_i});
  assign stable_d = fire ? raw_i : stable_q;

  assign status_o.fire    = fire;
  assign status_o.level_q = stable_q;
  assign status_o.level_d = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b1;
      stable_q      <= 1'b1;
      change_time_q <= '0;
    end else if (step_i) begin
      last_raw_q    <= raw_i;
      stable_q      <= stable_d;
      change_time_q <= change_time_d;
    end
  end

endmodule

// ===== rtl/dual_debounce_event_queue.sv =====
// top level: poll register, two debounce channels, event queue, result register
// depends on ddeq_pkg, ddeq_debounce and dual_debounce_event_queue_defines.svh
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+-------------------------------------
//  poll     | in        | in_valid_i / in_stall_o  | now_ms, btn_level, case_raw
//  event    | out       | out_valid_o/out_stall_i  | event_kind, event_time, event_case_closed
//  config   | in        | psel/penable/pready    | button window (0x0), case window (0x4)
//
// one beat per cycle sustained while out_stall_i is low; a poll is registered in the input register,
// where debounce, enqueue and dequeue are evaluated, then sits in the result register
// the event queue is flip-flops with no clear
// reset empties the queue and sets both channels to level one
// a stall on the event side backs up into in_stall_o once both registers hold beats
`include "dual_debounce_event_queue_defines.svh"

module dual_debounce_event_queue #(
  parameter int unsigned QUEUE_DEPTH = ddeq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // poll channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ddeq_pkg::TIME_W-1:0] now_ms_i,
  input  logic                        btn_level_i,
  input  logic                        case_raw_i,
  // event channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  event_kind_o,
  output logic [ddeq_pkg::TIME_W-1:0] event_time_o,
  output logic                        event_case_closed_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // configuration registers
  logic [ddeq_pkg::WINDOW_W-1:0] button_window_q, case_window_q;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_window_q <= ddeq_pkg::BUTTON_WINDOW_RST;
      case_window_q   <= ddeq_pkg::CASE_WINDOW_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        ddeq_pkg::REG_BUTTON_WINDOW: button_window_q <= pwdata[ddeq_pkg::WINDOW_W-1:0];
        ddeq_pkg::REG_CASE_WINDOW:   case_window_q   <= pwdata[ddeq_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ddeq_pkg::REG_BUTTON_WINDOW: prdata = {16'b0, button_window_q};
      ddeq_pkg::REG_CASE_WINDOW:   prdata = {16'b0, case_window_q};
      default:                     prdata = '0;
    endcase
  end

  // input register
  logic                        in_valid_q, in_valid_d;
  logic [ddeq_pkg::TIME_W-1:0] now_q;
  logic                        btn_level_q, case_raw_q;
  logic                        in_accept, advance;
  logic                        out_valid_q, out_valid_d;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_accept | (in_valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q       <= now_ms_i;
      btn_level_q <= btn_level_i;
      case_raw_q  <= case_raw_i;
    end
  end

  // debounce channels
  ddeq_pkg::deb_status_t button_st, case_st;

  ddeq_debounce u_button (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .now_i    (now_q),
    .raw_i    (btn_level_q),
    .window_i (button_window_q),
    .status_o (button_st)
  );

  ddeq_debounce u_case (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .now_i    (now_q),
    .raw_i    (case_raw_q),
    .window_i (case_window_q),
    .status_o (case_st)
  );

  // event queue
  ddeq_pkg::event_t  store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d, wr_ptr_case;
  logic [CNT_W-1:0]  fill_q, fill_d, fill_mid, fill_enq;
  logic              wr_button, wr_case, deq;
  ddeq_pkg::event_t  button_ev, case_ev, result_ev;

  assign button_ev.kind   = ddeq_pkg::EV_BUTTON;
  assign button_ev.stamp  = now_q;
  // case level from before this poll
  assign button_ev.closed = case_st.level_q;

  assign case_ev.kind   = case_st.level_d ? ddeq_pkg::EV_CASE_CLOSED
                                          : ddeq_pkg::EV_CASE_OPENED;
  assign case_ev.stamp  = now_q;
  assign case_ev.closed = case_st.level_d;

  always_comb begin
    wr_button   = button_st.fire & button_st.level_d & (fill_q < CNT_FULL);
    fill_mid    = fill_q + CNT_W'(wr_button);
    wr_case     = case_st.fire & (fill_mid < CNT_FULL);
    fill_enq    = fill_mid + CNT_W'(wr_case);
    wr_ptr_case = wr_button ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    wr_ptr_d    = wr_case ? ptr_inc(wr_ptr_case) : wr_ptr_case;
    deq         = (fill_enq != '0);
    fill_d      = fill_enq - CNT_W'(deq);
    rd_ptr_d    = deq ? ptr_inc(rd_ptr_q) : rd_ptr_q;

    // an empty queue hands over this poll's own first event
    priority if (fill_q != '0) begin
      result_ev = store_q[rd_ptr_q];
    end else if (wr_button) begin
      result_ev = button_ev;
    end else if (wr_case) begin
      result_ev = case_ev;
    end else begin
      result_ev.kind   = ddeq_pkg::EV_NONE;
      result_ev.stamp  = now_q;
      result_ev.closed = case_st.level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else if (advance) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && wr_button) begin
      store_q[wr_ptr_q] <= button_ev;
    end
    if (advance && wr_case) begin
      store_q[wr_ptr_case] <= case_ev;
    end
  end

  // result register
  ddeq_pkg::event_t out_q;

  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_ev;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign event_kind_o        = out_q.kind;
  assign event_time_o        = out_q.stamp;
  assign event_case_closed_o = out_q.closed;

  `DDEQ_ASSERT(a_fill_bound, fill_q <= CNT_FULL, "queue fill count beyond depth")
  `DDEQ_ASSERT_NEXT(a_advance_loads, advance, out_valid_q, "advanced beat lost")
  `DDEQ_ASSERT_NEXT(a_empty_stays, (fill_q == '0) && !wr_button && !wr_case,
                    fill_q == '0, "fill count grew without an event")

endmodule
